// ===== rtl/tfpc_pkg.sv =====
package tfpc_pkg;

   localparam int ADC_W         = 12;
   localparam int SCR_W         = 12;
   localparam int TD_W          = 8;
   localparam int DEB_W         = 16;
   localparam int OUT_W         = 16;
   localparam int THR_W         = 12;
   localparam int NUM_TARGETS   = 4;
   localparam int FRAC_BITS_DEF = 10;
   localparam int CW            = TD_W + ADC_W;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [1:0] REQ_SAMPLE  = 2'd0;
   localparam logic [1:0] REQ_TICK    = 2'd1;
   localparam logic [1:0] REQ_RESTART = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] CSR_SCREEN_COLS    = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SCREEN_ROWS    = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_TARGET_DIST    = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_DEBOUNCE_TICKS = 2'd3;

   localparam logic [SCR_W-1:0] SCREEN_COLS_RST    = 12'd640;
   localparam logic [SCR_W-1:0] SCREEN_ROWS_RST    = 12'd480;
   localparam logic [TD_W-1:0]  TARGET_DIST_RST    = 8'd10;
   localparam logic [DEB_W-1:0] DEBOUNCE_TICKS_RST = 16'd100;

   localparam logic [2:0] PHASE_FIRST = 3'd0;
   localparam logic [2:0] PHASE_DONE  = 3'd4;
   localparam logic [1:0] LAST_TARGET = 2'd3;

   typedef struct packed {
      logic [1:0]              target_ended;
      logic                    done_res;
      logic signed [OUT_W-1:0] x_low;
      logic signed [OUT_W-1:0] x_high;
      logic signed [OUT_W-1:0] y_low;
      logic signed [OUT_W-1:0] y_high;
      logic                    x_swapped;
      logic                    y_swapped;
      logic [THR_W-1:0]        press_threshold;
   } res_type;

   function automatic logic signed [OUT_W-1:0] sat16(input logic signed [CW+1:0] v);
      logic signed [CW+1:0] hi;
      logic signed [CW+1:0] lo;
      hi = (CW+2)'(32767);
      lo = -(CW+2)'(32768);
      if (v > hi) begin
         return 16'sd32767;
      end else if (v < lo) begin
         return -16'sd32768;
      end
      return v[OUT_W-1:0];
   endfunction

endpackage

// ===== rtl/tfpc_req_if.sv =====
interface tfpc_req_if import tfpc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [1:0]       req_type;
   logic [ADC_W-1:0] sample_x;
   logic [ADC_W-1:0] sample_y;
   logic [ADC_W-1:0] pressure;

   modport source (output valid, output req_type, output sample_x, output sample_y,
                   output pressure, input ready);
   modport sink   (input valid, input req_type, input sample_x, input sample_y,
                   input pressure, output ready);
endinterface

// ===== rtl/tfpc_rsp_if.sv =====
interface tfpc_rsp_if import tfpc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [1:0]              target_ended;
   logic                    done_res;
   logic signed [OUT_W-1:0] x_low;
   logic signed [OUT_W-1:0] x_high;
   logic signed [OUT_W-1:0] y_low;
   logic signed [OUT_W-1:0] y_high;
   logic                    x_swapped;
   logic                    y_swapped;
   logic [THR_W-1:0]        press_threshold;

   modport source (output valid, output target_ended, output done_res, output x_low,
                   output x_high, output y_low, output y_high, output x_swapped,
                   output y_swapped, output press_threshold, input ready);
   modport sink   (input valid, input target_ended, input done_res, input x_low,
                   input x_high, input y_low, input y_high, input x_swapped,
                   input y_swapped, input press_threshold, output ready);
endinterface

// ===== rtl/touch_four_point_calibrator_core.sv =====
// Ticks, restarts and samples that end no target are handled in idle, and req stays ready.
// A sample that ends target 0..2 puts its beat on rsp through ST_PUSH once rsp is free.
// Fourth target end: one shared restoring divider serves both axes in turn (LOAD, DIV, MUL and
// FIN per axis after PREP, then PUSH), and req is held off until the beat is registered.
// A new req beat is taken while a finished rsp beat still waits. Reset is synchronous,
// active high: phase, peaks, debounce, rsp valid and the csr registers return to defaults.
module touch_four_point_calibrator_core import tfpc_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   tfpc_req_if.sink              req_ch,
   tfpc_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int QW    = ADC_W + FRAC_BITS;
   localparam int PW    = TD_W + QW;
   localparam int CNT_W = $clog2(QW);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_PREP = 7'b0000010,
      ST_LOAD = 7'b0000100,
      ST_DIV  = 7'b0001000,
      ST_MUL  = 7'b0010000,
      ST_FIN  = 7'b0100000,
      ST_PUSH = 7'b1000000
   } state_type;

   state_type        state_ff, state_in;
   logic [SCR_W-1:0] cols_ff, cols_in, rows_ff, rows_in;
   logic [TD_W-1:0]  td_ff, td_in;
   logic [DEB_W-1:0] deb_ticks_ff, deb_ticks_in;
   logic [2:0]       phase_ff, phase_in;
   logic [ADC_W-1:0] peak_ff [NUM_TARGETS];
   logic [ADC_W-1:0] peak_in [NUM_TARGETS];
   logic [ADC_W-1:0] cap_x_ff [NUM_TARGETS];
   logic [ADC_W-1:0] cap_x_in [NUM_TARGETS];
   logic [ADC_W-1:0] cap_y_ff [NUM_TARGETS];
   logic [ADC_W-1:0] cap_y_in [NUM_TARGETS];
   logic             deb_active_ff, deb_active_in;
   logic [DEB_W-1:0] deb_left_ff, deb_left_in;
   logic             rsp_valid_ff, rsp_valid_in;
   res_type          res_ff, res_in;
   res_type          out_ff, out_in;
   logic [ADC_W-1:0] xmin_ff, xmin_in, xmax_ff, xmax_in;
   logic [ADC_W-1:0] ymin_ff, ymin_in, ymax_ff, ymax_in;
   logic             axis_ff, axis_in;
   logic [ADC_W-1:0] den_ff, den_in;
   logic [ADC_W-1:0] rem_ff, rem_in;
   logic [QW-1:0]    dq_ff, dq_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [PW-1:0]    prod_ff, prod_in;

   logic                req_fire;
   logic [ADC_W-1:0]    cur_peak;
   logic [ADC_W:0]      xa_sum, xb_sum, ya_sum, yb_sum;
   logic [ADC_W-1:0]    xa, xb, ya, yb;
   logic [ADC_W+1:0]    peak_sum;
   logic [ADC_W-1:0]    mean;
   logic [ADC_W+2:0]    mean7;
   logic [DEB_W-1:0]    deb_dec;
   logic [SCR_W-1:0]    scr_sel;
   logic [ADC_W-1:0]    min_sel, max_sel, span;
   logic signed [SCR_W+1:0] den_w;
   logic [ADC_W:0]      rem_sh, rem_diff;
   logic                rem_ge;
   logic [CW-1:0]       comp;
   logic signed [CW+1:0] low_w, high_w;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign cur_peak     = peak_ff[phase_ff[1:0]];

   assign xa_sum   = {1'b0, cap_x_ff[0]} + {1'b0, cap_x_ff[3]};
   assign xb_sum   = {1'b0, cap_x_ff[1]} + {1'b0, cap_x_ff[2]};
   assign ya_sum   = {1'b0, cap_y_ff[0]} + {1'b0, cap_y_ff[1]};
   assign yb_sum   = {1'b0, cap_y_ff[2]} + {1'b0, cap_y_ff[3]};
   assign xa       = xa_sum[ADC_W:1];
   assign xb       = xb_sum[ADC_W:1];
   assign ya       = ya_sum[ADC_W:1];
   assign yb       = yb_sum[ADC_W:1];
   assign peak_sum = {2'b00, peak_ff[0]} + {2'b00, peak_ff[1]}
                   + {2'b00, peak_ff[2]} + {2'b00, peak_ff[3]};
   assign mean     = peak_sum[ADC_W+1:2];
   assign mean7    = {mean, 3'b000} - {3'b000, mean};
   assign deb_dec  = (deb_left_ff != '0) ? deb_left_ff - 1'b1 : deb_left_ff;

   assign scr_sel = axis_ff ? rows_ff : cols_ff;
   assign min_sel = axis_ff ? ymin_ff : xmin_ff;
   assign max_sel = axis_ff ? ymax_ff : xmax_ff;
   assign span    = max_sel - min_sel;
   assign den_w   = $signed({2'b00, scr_sel}) - $signed({{(SCR_W+1-TD_W){1'b0}}, td_ff, 1'b0});

   assign rem_sh   = {rem_ff, dq_ff[QW-1]};
   assign rem_diff = rem_sh - {1'b0, den_ff};
   assign rem_ge   = (rem_sh >= {1'b0, den_ff});

   assign comp   = prod_ff[PW-1:FRAC_BITS];
   assign low_w  = $signed({2'b00, {(CW-ADC_W){1'b0}}, min_sel}) - $signed({2'b00, comp});
   assign high_w = $signed({2'b00, {(CW-ADC_W){1'b0}}, max_sel}) + $signed({2'b00, comp});

   always_comb begin
      state_in      = state_ff;
      cols_in       = cols_ff;
      rows_in       = rows_ff;
      td_in         = td_ff;
      deb_ticks_in  = deb_ticks_ff;
      phase_in      = phase_ff;
      peak_in       = peak_ff;
      cap_x_in      = cap_x_ff;
      cap_y_in      = cap_y_ff;
      deb_active_in = deb_active_ff;
      deb_left_in   = deb_left_ff;
      rsp_valid_in  = rsp_valid_ff;
      res_in        = res_ff;
      out_in        = out_ff;
      xmin_in       = xmin_ff;
      xmax_in       = xmax_ff;
      ymin_in       = ymin_ff;
      ymax_in       = ymax_ff;
      axis_in       = axis_ff;
      den_in        = den_ff;
      rem_in        = rem_ff;
      dq_in         = dq_ff;
      cnt_in        = cnt_ff;
      prod_in       = prod_ff;

      if (csr_we) begin
         case (csr_addr)
            CSR_SCREEN_COLS:    cols_in      = csr_wdata[SCR_W-1:0];
            CSR_SCREEN_ROWS:    rows_in      = csr_wdata[SCR_W-1:0];
            CSR_TARGET_DIST:    td_in        = csr_wdata[TD_W-1:0];
            CSR_DEBOUNCE_TICKS: deb_ticks_in = csr_wdata[DEB_W-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_ch.req_type)
                  REQ_TICK: begin
                     if (deb_active_ff) begin
                        deb_left_in = deb_dec;
                        if (deb_dec == '0) begin
                           deb_active_in = 1'b0;
                        end
                     end
                  end
                  REQ_RESTART: begin
                     phase_in      = PHASE_FIRST;
                     peak_in       = '{default: '0};
                     deb_active_in = 1'b0;
                     deb_left_in   = '0;
                  end
                  REQ_SAMPLE: begin
                     if (!deb_active_ff && (phase_ff < PHASE_DONE)) begin
                        if (req_ch.pressure > cur_peak) begin
                           peak_in[phase_ff[1:0]]  = req_ch.pressure;
                           cap_x_in[phase_ff[1:0]] = req_ch.sample_x;
                           cap_y_in[phase_ff[1:0]] = req_ch.sample_y;
                        end else if (req_ch.pressure < (cur_peak >> 1)) begin
                           res_in              = '0;
                           res_in.target_ended = phase_ff[1:0];
                           if (phase_ff[1:0] == LAST_TARGET) begin
                              phase_in = PHASE_DONE;
                              state_in = ST_PREP;
                           end else begin
                              phase_in      = phase_ff + 3'd1;
                              deb_left_in   = deb_ticks_ff;
                              deb_active_in = (deb_ticks_ff != '0);
                              state_in      = ST_PUSH;
                           end
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_PREP: begin
            res_in.done_res        = 1'b1;
            res_in.x_swapped       = (xa > xb);
            res_in.y_swapped       = (ya > yb);
            res_in.press_threshold = mean7[ADC_W+2:3];
            xmin_in  = (xa > xb) ? xb : xa;
            xmax_in  = (xa > xb) ? xa : xb;
            ymin_in  = (ya > yb) ? yb : ya;
            ymax_in  = (ya > yb) ? ya : yb;
            axis_in  = 1'b0;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            rem_in = '0;
            cnt_in = '0;
            if (den_w <= 0) begin
               dq_in    = '0;
               state_in = ST_MUL;
            end else begin
               den_in   = den_w[ADC_W-1:0];
               dq_in    = {span, {FRAC_BITS{1'b0}}};
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = rem_ge ? rem_diff[ADC_W-1:0] : rem_sh[ADC_W-1:0];
            dq_in  = {dq_ff[QW-2:0], rem_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(QW - 1)) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = {{QW{1'b0}}, td_ff} * {{TD_W{1'b0}}, dq_ff};
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (axis_ff) begin
               res_in.y_low  = sat16(low_w);
               res_in.y_high = sat16(high_w);
               state_in      = ST_PUSH;
            end else begin
               res_in.x_low  = sat16(low_w);
               res_in.x_high = sat16(high_w);
               axis_in       = 1'b1;
               state_in      = ST_LOAD;
            end
         end
         ST_PUSH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               out_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cols_ff       <= SCREEN_COLS_RST;
         rows_ff       <= SCREEN_ROWS_RST;
         td_ff         <= TARGET_DIST_RST;
         deb_ticks_ff  <= DEBOUNCE_TICKS_RST;
         phase_ff      <= PHASE_FIRST;
         peak_ff       <= '{default: '0};
         deb_active_ff <= 1'b0;
         deb_left_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cols_ff       <= cols_in;
         rows_ff       <= rows_in;
         td_ff         <= td_in;
         deb_ticks_ff  <= deb_ticks_in;
         phase_ff      <= phase_in;
         peak_ff       <= peak_in;
         deb_active_ff <= deb_active_in;
         deb_left_ff   <= deb_left_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cap_x_ff <= cap_x_in;
      cap_y_ff <= cap_y_in;
      res_ff   <= res_in;
      out_ff   <= out_in;
      xmin_ff  <= xmin_in;
      xmax_ff  <= xmax_in;
      ymin_ff  <= ymin_in;
      ymax_ff  <= ymax_in;
      axis_ff  <= axis_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      dq_ff    <= dq_in;
      cnt_ff   <= cnt_in;
      prod_ff  <= prod_in;
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.target_ended    = out_ff.target_ended;
   assign rsp_ch.done_res        = out_ff.done_res;
   assign rsp_ch.x_low           = out_ff.x_low;
   assign rsp_ch.x_high          = out_ff.x_high;
   assign rsp_ch.y_low           = out_ff.y_low;
   assign rsp_ch.y_high          = out_ff.y_high;
   assign rsp_ch.x_swapped       = out_ff.x_swapped;
   assign rsp_ch.y_swapped       = out_ff.y_swapped;
   assign rsp_ch.press_threshold = out_ff.press_threshold;

endmodule

// ===== rtl/tfpc_checker.sv =====
module tfpc_checker import tfpc_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [1:0]              target_ended,
   input logic                    done_res,
   input logic signed [OUT_W-1:0] x_low,
   input logic signed [OUT_W-1:0] x_high,
   input logic signed [OUT_W-1:0] y_low,
   input logic signed [OUT_W-1:0] y_high,
   input logic                    x_swapped,
   input logic                    y_swapped,
   input logic [THR_W-1:0]        press_threshold
);

   // stalled beat stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (done_res == (target_ended == LAST_TARGET)))
      else $error("done flag does not match last target");

   a_mid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !done_res |-> (x_low == 0) && (x_high == 0) && (y_low == 0)
         && (y_high == 0) && !x_swapped && !y_swapped && (press_threshold == 0))
      else $error("intermediate beat carries nonzero fields");

   a_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && done_res |-> (x_low <= x_high) && (y_low <= y_high))
      else $error("calibration extremes out of order");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind touch_four_point_calibrator_core tfpc_checker u_tfpc_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .target_ended    (rsp_ch.target_ended),
   .done_res        (rsp_ch.done_res),
   .x_low           (rsp_ch.x_low),
   .x_high          (rsp_ch.x_high),
   .y_low           (rsp_ch.y_low),
   .y_high          (rsp_ch.y_high),
   .x_swapped       (rsp_ch.x_swapped),
   .y_swapped       (rsp_ch.y_swapped),
   .press_threshold (rsp_ch.press_threshold)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import tfpc_pkg::*;

   localparam int HALF_PERIOD    = 10;
   localparam int RESET_CYCLES   = 6;
   localparam int DRAIN_CYCLES   = 64;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DIR_ROWS       = 25;
   localparam int MAX_REPORTS    = 10;
   localparam int PHASES         = 8;
   localparam int BLANK_TICK_CAP = 16;

   localparam logic [1:0] REQ_UNKNOWN = 2'd3;

   typedef enum logic [1:0] {
      FROM_MODEL,
      NO_BEAT,
      TARGET_BEAT
   } beat_src_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic [ADC_W-1:0] x;
      logic [ADC_W-1:0] y;
      logic [ADC_W-1:0] z;
      beat_src_type     src;
      logic [1:0]       tgt;
   } beat_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   tfpc_req_if req_bus ();
   tfpc_rsp_if rsp_bus ();

   touch_four_point_calibrator_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // calibrator mirror
   logic [SCR_W-1:0] cfg_cols;
   logic [SCR_W-1:0] cfg_rows;
   logic [TD_W-1:0]  cfg_dist;
   logic [DEB_W-1:0] cfg_blank;
   logic [2:0]       cal_phase;
   logic [ADC_W-1:0] peak_z [NUM_TARGETS];
   logic [ADC_W-1:0] cap_x  [NUM_TARGETS];
   logic [ADC_W-1:0] cap_y  [NUM_TARGETS];
   logic             blank_on;
   logic [DEB_W-1:0] blank_left;

   beat_type req_backlog [$];
   res_type  cal_results_q [$];
   beat_type on_bus;
   logic     beat_open = 1'b0;
   int       issued = 0;
   int       n_taken = 0;
   int       n_eff = 0;
   int       n_faults = 0;
   int       send_idle_pct = 0;
   int       stall_pct = 0;
   beat_type dir_rows [DIR_ROWS];

   function automatic logic signed [OUT_W-1:0] clamp16(input longint v);
      if (v > 32767) begin
         return 16'sh7fff;
      end else if (v < -32768) begin
         return 16'sh8000;
      end
      return v[OUT_W-1:0];
   endfunction

   function automatic longint widen(input int span, input int screen);
      longint den;
      longint ratio;
      den = longint'(screen) - 2 * longint'(int'(cfg_dist));
      if (den <= 0) begin
         return 0;
      end
      ratio = (longint'(span) << FRAC_BITS_DEF) / den;
      return (longint'(int'(cfg_dist)) * ratio) >>> FRAC_BITS_DEF;
   endfunction

   function automatic logic calib_step(input beat_type b, output res_type r, output logic eff);
      int     p;
      int     sum;
      int     xlo, xhi, ylo, yhi, t;
      longint xw, yw;
      r = '0;
      eff = 1'b0;
      case (b.kind)
         REQ_TICK: begin
            if (blank_on) begin
               eff = 1'b1;
               if (blank_left != 0) blank_left = blank_left - 1'b1;
               if (blank_left == 0) blank_on = 1'b0;
            end
            return 1'b0;
         end
         REQ_RESTART: begin
            eff = 1'b1;
            cal_phase = PHASE_FIRST;
            foreach (peak_z[i]) peak_z[i] = '0;
            blank_on = 1'b0;
            blank_left = '0;
            return 1'b0;
         end
         REQ_SAMPLE: ;
         default: return 1'b0;
      endcase
      if (blank_on || cal_phase == PHASE_DONE) begin
         return 1'b0;
      end
      eff = 1'b1;
      p = int'(cal_phase);
      if (b.z > peak_z[p]) begin
         peak_z[p] = b.z;
         cap_x[p] = b.x;
         cap_y[p] = b.y;
         return 1'b0;
      end
      if (b.z >= peak_z[p] / 2) begin
         return 1'b0;
      end
      r.target_ended = p[1:0];
      if (p[1:0] == LAST_TARGET) begin
         cal_phase = PHASE_DONE;
         sum = 0;
         foreach (peak_z[i]) sum += int'(peak_z[i]);
         r.press_threshold = THR_W'(((sum / 4) * 7) / 8);
         xlo = (int'(cap_x[0]) + int'(cap_x[3])) / 2;
         xhi = (int'(cap_x[1]) + int'(cap_x[2])) / 2;
         ylo = (int'(cap_y[0]) + int'(cap_y[1])) / 2;
         yhi = (int'(cap_y[2]) + int'(cap_y[3])) / 2;
         if (xlo > xhi) begin
            r.x_swapped = 1'b1;
            t = xlo; xlo = xhi; xhi = t;
         end
         if (ylo > yhi) begin
            r.y_swapped = 1'b1;
            t = ylo; ylo = yhi; yhi = t;
         end
         xw = widen(xhi - xlo, int'(cfg_cols));
         yw = widen(yhi - ylo, int'(cfg_rows));
         r.done_res = 1'b1;
         r.x_low  = clamp16(longint'(xlo) - xw);
         r.x_high = clamp16(longint'(xhi) + xw);
         r.y_low  = clamp16(longint'(ylo) - yw);
         r.y_high = clamp16(longint'(yhi) + yw);
      end else begin
         cal_phase = 3'(p + 1);
         blank_left = cfg_blank;
         blank_on = (cfg_blank != 0);
      end
      return 1'b1;
   endfunction

   function automatic string beat_str(input res_type r);
      return $sformatf("tgt=%0d done=%0b x=[%0d,%0d] y=[%0d,%0d] swap=%0b/%0b thr=%0d",
                       r.target_ended, r.done_res, r.x_low, r.x_high, r.y_low, r.y_high,
                       r.x_swapped, r.y_swapped, r.press_threshold);
   endfunction

   // req driver: one beat in flight, changes only at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!beat_open) begin
         if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            on_bus = req_backlog.pop_front();
            beat_open = 1'b1;
            req_bus.valid    <= 1'b1;
            req_bus.req_type <= on_bus.kind;
            req_bus.sample_x <= on_bus.x;
            req_bus.sample_y <= on_bus.y;
            req_bus.pressure <= on_bus.z;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_bus.ready <= $urandom_range(0, 99) >= stall_pct;
   end

   always @(posedge clock) begin : take_req
      res_type pred;
      res_type typed;
      logic    made;
      logic    eff;
      if (!reset && req_bus.valid && req_bus.ready) begin
         beat_open = 1'b0;
         made = calib_step(on_bus, pred, eff);
         case (on_bus.src)
            FROM_MODEL: begin
               if (made) cal_results_q.push_back(pred);
            end
            TARGET_BEAT: begin
               typed = '0;
               typed.target_ended = on_bus.tgt;
               cal_results_q.push_back(typed);
            end
            default: ;
         endcase
         if (eff) n_eff++;
         n_taken++;
      end
   end

   always @(posedge clock) begin : check_rsp
      res_type got;
      res_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.target_ended, rsp_bus.done_res, rsp_bus.x_low, rsp_bus.x_high,
                 rsp_bus.y_low, rsp_bus.y_high, rsp_bus.x_swapped, rsp_bus.y_swapped,
                 rsp_bus.press_threshold};
         if (cal_results_q.size() == 0) begin
            n_faults++;
            if (n_faults <= MAX_REPORTS) $display("rsp beat with nothing owed: %s", beat_str(got));
         end else begin
            want = cal_results_q.pop_front();
            if (got.target_ended !== want.target_ended || got.done_res !== want.done_res ||
                got.x_low !== want.x_low || got.x_high !== want.x_high ||
                got.y_low !== want.y_low || got.y_high !== want.y_high ||
                got.x_swapped !== want.x_swapped || got.y_swapped !== want.y_swapped ||
                got.press_threshold !== want.press_threshold) begin
               n_faults++;
               if (n_faults <= MAX_REPORTS) begin
                  $display("rsp mismatch at %0t\n  want %s\n  got  %s", $realtime,
                           beat_str(want), beat_str(got));
               end
            end
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("testbench: done, errors");
      $finish;
   end

   task automatic push_beat(input beat_type b);
      issued++;
      req_backlog.push_back(b);
      wait (n_taken == issued);
   endtask

   task automatic send(input logic [1:0] kind, input logic [ADC_W-1:0] x, y, z);
      beat_type b;
      b = '{kind, x, y, z, FROM_MODEL, 2'd0};
      push_beat(b);
   endtask

   function automatic logic [ADC_W-1:0] rnd12();
      return ADC_W'($urandom_range(0, 4095));
   endfunction

   task automatic cfg_write(input logic [CSR_ADDR_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_SCREEN_COLS:    cfg_cols  = data[SCR_W-1:0];
         CSR_SCREEN_ROWS:    cfg_rows  = data[SCR_W-1:0];
         CSR_TARGET_DIST:    cfg_dist  = data[TD_W-1:0];
         CSR_DEBOUNCE_TICKS: cfg_blank = data[DEB_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      while (cal_results_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_noise(input int n);
      repeat (n) send(2'($urandom_range(0, 3)), rnd12(), rnd12(), rnd12());
   endtask

   // one pass over the four corners, with noise mixed in
   task automatic run_calibration();
      int guard;
      int pk;
      if (cal_phase != PHASE_FIRST || $urandom_range(0, 3) == 0) begin
         send(REQ_RESTART, rnd12(), rnd12(), rnd12());
      end
      guard = 0;
      while (cal_phase != PHASE_DONE && guard < 12) begin
         guard++;
         repeat ($urandom_range(1, 4)) begin
            send(REQ_SAMPLE, rnd12(), rnd12(), ADC_W'($urandom_range(2, 4095)));
         end
         if ($urandom_range(0, 4) == 0) send_noise($urandom_range(1, 3));
         if (!blank_on && cal_phase != PHASE_DONE) begin
            pk = int'(peak_z[cal_phase[1:0]]);
            if ($urandom_range(0, 3) == 0) begin
               send(REQ_SAMPLE, rnd12(), rnd12(), ADC_W'($urandom_range(pk / 2, pk)));
            end
            if (pk >= 2) begin
               send(REQ_SAMPLE, rnd12(), rnd12(), ADC_W'($urandom_range(0, pk / 2 - 1)));
            end
         end
         if (blank_on) begin
            if (blank_left > BLANK_TICK_CAP) begin
               send(REQ_RESTART, rnd12(), rnd12(), rnd12());
               return;
            end
            while (blank_on) begin
               if ($urandom_range(0, 3) == 0) send(REQ_SAMPLE, rnd12(), rnd12(), rnd12());
               send(REQ_TICK, rnd12(), rnd12(), rnd12());
            end
         end
      end
   endtask

   initial begin : stimulus
      int  c, r, d, k;
      int  stop_at;
      logic held;

      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.req_type = REQ_SAMPLE;
      req_bus.sample_x = '0;
      req_bus.sample_y = '0;
      req_bus.pressure = '0;
      rsp_bus.ready = 1'b0;
      cfg_cols = SCREEN_COLS_RST;
      cfg_rows = SCREEN_ROWS_RST;
      cfg_dist = TARGET_DIST_RST;
      cfg_blank = DEBOUNCE_TICKS_RST;
      cal_phase = PHASE_FIRST;
      foreach (peak_z[i]) begin
         peak_z[i] = '0;
         cap_x[i] = '0;
         cap_y[i] = '0;
      end
      blank_on = 1'b0;
      blank_left = '0;
      held = 1'b0;

      // corners NW, NE, SE, SW placed so both axes come out swapped
      dir_rows = '{
         '{REQ_TICK,    12'h000, 12'h000, 12'h000, NO_BEAT,     2'd0},
         '{REQ_UNKNOWN, 12'hfff, 12'hfff, 12'hfff, NO_BEAT,     2'd0},
         '{REQ_SAMPLE,  12'h000, 12'h000, 12'h000, NO_BEAT,     2'd0},
         '{REQ_SAMPLE,  12'hfff, 12'hfff, 12'hfff, NO_BEAT,     2'd0},
         '{REQ_SAMPLE,  12'h000, 12'h000, 12'd2048, NO_BEAT,    2'd0},
         '{REQ_SAMPLE,  12'h000, 12'h000, 12'd2047, NO_BEAT,    2'd0},
         '{REQ_SAMPLE,  12'h000, 12'h000, 12'd2046, TARGET_BEAT, 2'd0},
         '{REQ_SAMPLE,  12'h000, 12'h000, 12'hfff, NO_BEAT,     2'd0},
         '{REQ_TICK,    12'hfff, 12'hfff, 12'hfff, NO_BEAT,     2'd0},
         '{REQ_TICK,    12'h000, 12'h000, 12'h000, NO_BEAT,     2'd0},
         '{REQ_SAMPLE,  12'h000, 12'hfff, 12'hfff, NO_BEAT,     2'd0},
         '{REQ_SAMPLE,  12'hfff, 12'h000, 12'h000, TARGET_BEAT, 2'd1},
         '{REQ_TICK,    12'h000, 12'h000, 12'h000, NO_BEAT,     2'd0},
         '{REQ_TICK,    12'h000, 12'h000, 12'h000, NO_BEAT,     2'd0},
         '{REQ_SAMPLE,  12'h000, 12'h000, 12'hfff, NO_BEAT,     2'd0},
         '{REQ_SAMPLE,  12'h000, 12'h000, 12'h000, TARGET_BEAT, 2'd2},
         '{REQ_TICK,    12'h000, 12'h000, 12'h000, NO_BEAT,     2'd0},
         '{REQ_TICK,    12'h000, 12'h000, 12'h000, NO_BEAT,     2'd0},
         '{REQ_SAMPLE,  12'hfff, 12'h000, 12'hfff, NO_BEAT,     2'd0},
         '{REQ_SAMPLE,  12'h000, 12'h000, 12'h000, FROM_MODEL,  2'd0},
         '{REQ_SAMPLE,  12'h000, 12'h000, 12'hfff, NO_BEAT,     2'd0},
         '{REQ_RESTART, 12'h000, 12'h000, 12'h000, NO_BEAT,     2'd0},
         '{REQ_SAMPLE,  12'h123, 12'h456, 12'd3,   NO_BEAT,     2'd0},
         '{REQ_SAMPLE,  12'h000, 12'h000, 12'h000, TARGET_BEAT, 2'd0},
         '{REQ_RESTART, 12'hfff, 12'hfff, 12'hfff, NO_BEAT,     2'd0}
      };

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      cfg_write(CSR_DEBOUNCE_TICKS, 16'd2);
      foreach (dir_rows[i]) push_beat(dir_rows[i]);

      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         case (p)
            0: begin c = 640;  r = 480;  d = 10;  k = 3;     end
            1: begin c = 4095; r = 4095; d = 1;   k = 0;     end
            2: begin c = 1;    r = 1;    d = 255; k = 1;     end
            3: begin c = 511;  r = 600;  d = 255; k = 2;     end
            4: begin c = 100;  r = 4095; d = 50;  k = 65535; end
            default: begin
               // junk above the register width must be dropped
               c = $urandom_range(1, 4095) | ($urandom_range(0, 15) << SCR_W);
               r = $urandom_range(1, 4095) | ($urandom_range(0, 15) << SCR_W);
               d = $urandom_range(1, 255) | ($urandom_range(0, 255) << TD_W);
               k = $urandom_range(0, 4);
            end
         endcase
         cfg_write(CSR_SCREEN_COLS, CSR_DATA_W'(c));
         cfg_write(CSR_SCREEN_ROWS, CSR_DATA_W'(r));
         cfg_write(CSR_TARGET_DIST, CSR_DATA_W'(d));
         cfg_write(CSR_DEBOUNCE_TICKS, CSR_DATA_W'(k));
         case (p % 4)
            1: begin send_idle_pct = 71; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 71; end
            3: begin send_idle_pct = 7;  stall_pct = 7;  end
            default: begin send_idle_pct = 0; stall_pct = 0; end
         endcase
         stop_at = n_eff + ((p == 4) ? 60 : 130);
         while (n_eff < stop_at) begin
            run_calibration();
            if (p == 1 && !held && n_eff >= stop_at - 65) begin
               while (cal_results_q.size() != 0) @(posedge clock);
               held = 1'b1;
            end
         end
      end

      while (cal_results_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (n_faults == 0 && cal_results_q.size() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/tfpc_pkg.sv
rtl/tfpc_req_if.sv
rtl/tfpc_rsp_if.sv
rtl/touch_four_point_calibrator_core.sv
rtl/tfpc_checker.sv
sim/testbench.sv
